[rtl/core/kwm_pkg.sv]
// Shared types and constants for the k-way sorted list merge.
`default_nettype none
package kwm_pkg;

	localparam int CAPACITY = 1024;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = AW + 1;
	localparam int VW = 32;
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic signed [VW-1:0]  value;
		logic                  eol;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MRD,
		ST_MCMP,
		ST_CRD,
		ST_CWR,
		ST_RDOUT
	} state_t;

endpackage
`default_nettype wire

[rtl/core/kwm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kwm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/core/kwm_front.sv]
// Front end: accepts and classifies commands and queues them for the back end.
`default_nettype none
module kwm_front
	import kwm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [1:0]           op,
	input  wire logic signed [VW-1:0] element_value,
	input  wire logic                 end_of_list,
	input  wire logic                 pop,
	output logic                      busy,
	output queue_out_t                qout
);

	localparam int PW = $clog2(QDEPTH);

	item_t          entry_q [QDEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    count_q;
	op_t            cls;
	logic           push;
	logic           do_pop;

	always_comb begin
		case (op_t'(op))
			OP_PUSH:  cls = OP_PUSH;
			OP_READ:  cls = OP_READ;
			OP_CLEAR: cls = OP_CLEAR;
			default:  cls = OP_NONE;
		endcase
	end

	assign busy = (count_q == (PW+1)'(QDEPTH));
	assign push = start && !busy && (cls != OP_NONE);
	assign do_pop = pop && (count_q != '0);
	assign qout.valid = (count_q != '0);
	assign qout.item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{op: cls, value: element_value, eol: end_of_list};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/kwm_back.sv]
// Back end: merges pushed elements into the ping-pong buffers, serves reads and handles clears.
`default_nettype none
module kwm_back
	import kwm_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire queue_out_t    qin,
	output logic               pop,
	output logic               done,
	output logic signed [VW-1:0] merged_value,
	output logic               valid_res,
	output logic               last_element,
	output logic               overflow
);

	state_t          state_q, state_d;
	item_t           cur_q, cur_d;
	logic            csel_q, csel_d;
	logic [CW-1:0]   cc_q, cc_d;
	logic [CW-1:0]   bc_q, bc_d;
	logic [CW-1:0]   mp_q, mp_d;
	logic [CW-1:0]   rp_q, rp_d;
	logic            ovf_q, ovf_d;
	logic            done_q, done_d;
	logic [VW-1:0]   value_q, value_d;
	logic            valid_q, valid_d;
	logic            last_q, last_d;
	logic            ovfo_q, ovfo_d;

	logic            app;
	logic [VW-1:0]   app_val;
	logic            we;
	logic [AW-1:0]   raddr;
	logic [VW-1:0]   rdata_even;
	logic [VW-1:0]   rdata_odd;
	logic [VW-1:0]   rdata;

	assign rdata = csel_q ? rdata_odd : rdata_even;

	kwm_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_ram_even (
		.clk   (clk),
		.we    (we && csel_q),
		.waddr (bc_q[AW-1:0]),
		.wdata (app_val),
		.raddr (raddr),
		.rdata (rdata_even)
	);

	kwm_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_ram_odd (
		.clk   (clk),
		.we    (we && !csel_q),
		.waddr (bc_q[AW-1:0]),
		.wdata (app_val),
		.raddr (raddr),
		.rdata (rdata_odd)
	);

	always_comb begin
		state_d = state_q;
		cur_d = cur_q;
		csel_d = csel_q;
		cc_d = cc_q;
		bc_d = bc_q;
		mp_d = mp_q;
		rp_d = rp_q;
		ovf_d = ovf_q;
		done_d = 1'b0;
		value_d = value_q;
		valid_d = valid_q;
		last_d = last_q;
		ovfo_d = ovfo_q;
		app = 1'b0;
		app_val = cur_q.value;
		we = 1'b0;
		pop = 1'b0;
		raddr = mp_q[AW-1:0];

		case (state_q)
			ST_IDLE: begin
				raddr = rp_q[AW-1:0];
				if (qin.valid) begin
					pop = 1'b1;
					cur_d = qin.item;
					case (qin.item.op)
						OP_PUSH: state_d = ST_MRD;
						OP_READ: begin
							if (rp_q < cc_q) begin
								state_d = ST_RDOUT;
							end else begin
								done_d = 1'b1;
								value_d = '0;
								valid_d = 1'b0;
								last_d = 1'b0;
								ovfo_d = ovf_q;
							end
						end
						OP_CLEAR: begin
							csel_d = 1'b0;
							cc_d = '0;
							bc_d = '0;
							mp_d = '0;
							rp_d = '0;
							ovf_d = 1'b0;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_MRD: begin
				if (mp_q < cc_q) begin
					state_d = ST_MCMP;
				end else begin
					app = 1'b1;
					state_d = cur_q.eol ? ST_CRD : ST_IDLE;
				end
			end
			ST_MCMP: begin
				if ($signed(rdata) <= cur_q.value) begin
					app = 1'b1;
					app_val = rdata;
					mp_d = mp_q + CW'(1);
					state_d = ST_MRD;
				end else begin
					app = 1'b1;
					state_d = cur_q.eol ? ST_CRD : ST_IDLE;
				end
			end
			ST_CRD: begin
				if (mp_q < cc_q) begin
					state_d = ST_CWR;
				end else begin
					csel_d = !csel_q;
					cc_d = bc_q;
					bc_d = '0;
					mp_d = '0;
					rp_d = '0;
					state_d = ST_IDLE;
				end
			end
			ST_CWR: begin
				app = 1'b1;
				app_val = rdata;
				mp_d = mp_q + CW'(1);
				state_d = ST_CRD;
			end
			ST_RDOUT: begin
				done_d = 1'b1;
				value_d = rdata;
				valid_d = 1'b1;
				last_d = ((rp_q + CW'(1)) == cc_q);
				ovfo_d = ovf_q;
				rp_d = rp_q + CW'(1);
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase

		if (app) begin
			if (bc_q < CW'(CAPACITY)) begin
				we = 1'b1;
				bc_d = bc_q + CW'(1);
			end else begin
				ovf_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			csel_q <= 1'b0;
			cc_q <= '0;
			bc_q <= '0;
			mp_q <= '0;
			rp_q <= '0;
			ovf_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			csel_q <= csel_d;
			cc_q <= cc_d;
			bc_q <= bc_d;
			mp_q <= mp_d;
			rp_q <= rp_d;
			ovf_q <= ovf_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		value_q <= value_d;
		valid_q <= valid_d;
		last_q <= last_d;
		ovfo_q <= ovfo_d;
	end

	assign done = done_q;
	assign merged_value = $signed(value_q);
	assign valid_res = valid_q;
	assign last_element = last_q;
	assign overflow = ovfo_q;

endmodule
`default_nettype wire

[rtl/core/k_way_sorted_list_merge_top.sv]
// Top level of the k-way sorted list merge: front end, command queue and back end.
//
// Channel   Direction  Handshake             Words
// command   in         start high, busy low  op, element_value, end_of_list
// result    out        done strobe, 1 cycle  merged_value, valid_res, last_element, overflow
//
// The single read port paces the back end. A read passes the idle and read-out states,
// and a read past the end is answered in idle. A push is dispatched from idle, passes
// merge-read and merge-compare per committed element merged ahead of it, and is appended
// at the end or when a larger element stops the merge; a list end copies the rest and commits.
// Reset is asynchronous and clears all counters; buffer contents are left as they are.
// Commands queue two deep, so busy rises only while the back end is working.
`default_nettype none
module k_way_sorted_list_merge_top
	import kwm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [1:0]           op,
	input  wire logic signed [VW-1:0] element_value,
	input  wire logic                 end_of_list,
	output logic                      done,
	output logic signed [VW-1:0]      merged_value,
	output logic                      valid_res,
	output logic                      last_element,
	output logic                      overflow
);

	queue_out_t qout;
	logic       pop;

	kwm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.op            (op),
		.element_value (element_value),
		.end_of_list   (end_of_list),
		.pop           (pop),
		.busy          (busy),
		.qout          (qout)
	);

	kwm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qin          (qout),
		.pop          (pop),
		.done         (done),
		.merged_value (merged_value),
		.valid_res    (valid_res),
		.last_element (last_element),
		.overflow     (overflow)
	);

endmodule
`default_nettype wire
